>>> rtl/core/sto_pkg.sv
`timescale 1ns / 1ps

package sto_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int DOT_W   = 68;
  localparam int VAL_W   = 137;
  localparam int NUM_W   = 140;
  localparam int FRAC_W  = 32;
  localparam int PLC_W   = 68;
  localparam int DIST_W  = 63;
  localparam int RAD_W   = 31;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_CX  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CY  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CZ  = 2'd2;
  localparam logic [IDX_W-1:0] REG_RAD = 2'd3;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [2*DIFF_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]    dot_t;
  typedef logic signed [2*DOT_W-1:0]  vprod_t;
  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic signed [NUM_W-1:0]    wnum_t;
  typedef logic signed [PLC_W-1:0]    plc_t;
  typedef logic [FRAC_W:0]            wgt_t;

endpackage

>>> rtl/core/sphere_triangle_overlap_test.sv
`timescale 1ns / 1ps

// Channel  Signals                                   Direction
// input    in_valid/in_ready, a_*..c_*, last_triangle  in
// result   out_valid/out_ready, hit, near_*, dist_squared, last_out  out
// config   cfg_valid/cfg_ready, cfg_index, cfg_data  in
//
// One triangle is accepted per cycle unless the result stalls; the pipeline is
// the 32-stage weight dividers plus 12 stages of dot products, region logic and
// point placement. Reset clears the valid bits and the configuration registers.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.

module sphere_triangle_overlap_test (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sto_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sto_pkg::COORD_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sto_pkg::COORD_W-1:0] a_x,
  input  logic signed [sto_pkg::COORD_W-1:0] a_y,
  input  logic signed [sto_pkg::COORD_W-1:0] a_z,
  input  logic signed [sto_pkg::COORD_W-1:0] b_x,
  input  logic signed [sto_pkg::COORD_W-1:0] b_y,
  input  logic signed [sto_pkg::COORD_W-1:0] b_z,
  input  logic signed [sto_pkg::COORD_W-1:0] c_x,
  input  logic signed [sto_pkg::COORD_W-1:0] c_y,
  input  logic signed [sto_pkg::COORD_W-1:0] c_z,
  input  logic                              last_triangle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [sto_pkg::COORD_W-1:0] near_x,
  output logic signed [sto_pkg::COORD_W-1:0] near_y,
  output logic signed [sto_pkg::COORD_W-1:0] near_z,
  output logic [sto_pkg::DIST_W-1:0]        dist_squared,
  output logic                              last_out
);

  localparam int N    = sto_pkg::FRAC_W;
  localparam int NSTG = N + 12;
  localparam int DVW  = sto_pkg::NUM_W - 1;

  typedef struct packed {
    sto_pkg::coord_t [2:0] a;
    sto_pkg::coord_t [2:0] b;
    sto_pkg::coord_t [2:0] c;
    sto_pkg::diff_t  [2:0] ab;
    sto_pkg::diff_t  [2:0] ac;
    sto_pkg::diff_t  [2:0] bc;
    logic                  last;
  } geo_t;

  typedef struct packed {
    sto_pkg::coord_t [2:0] base;
    sto_pkg::diff_t  [2:0] e1;
    sto_pkg::diff_t  [2:0] e2;
    logic                  z1;
    logic                  o1;
    logic                  z2;
    logic                  o2;
    logic                  last;
  } fin_t;

  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv       = !vld[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  sto_pkg::coord_t           cx, cy, cz;
  logic [sto_pkg::RAD_W-1:0] rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      cz  <= '0;
      rad <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sto_pkg::REG_CX:  cx  <= sto_pkg::coord_t'(cfg_data);
        sto_pkg::REG_CY:  cy  <= sto_pkg::coord_t'(cfg_data);
        sto_pkg::REG_CZ:  cz  <= sto_pkg::coord_t'(cfg_data);
        sto_pkg::REG_RAD: rad <= cfg_data[sto_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  sto_pkg::coord_t in_a [3];
  sto_pkg::coord_t in_b [3];
  sto_pkg::coord_t in_c [3];
  sto_pkg::coord_t pc   [3];

  always_comb begin
    in_a[0] = a_x; in_a[1] = a_y; in_a[2] = a_z;
    in_b[0] = b_x; in_b[1] = b_y; in_b[2] = b_z;
    in_c[0] = c_x; in_c[1] = c_y; in_c[2] = c_z;
    pc[0]   = cx;  pc[1]   = cy;  pc[2]   = cz;
  end

  // Stage 1: edge vectors and center offsets.
  geo_t           geo1, geo2, geo3, geo4, geo5, geo6;
  sto_pkg::diff_t s1_ap [3];
  sto_pkg::diff_t s1_bp [3];
  sto_pkg::diff_t s1_cp [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        geo1.a[i]  <= in_a[i];
        geo1.b[i]  <= in_b[i];
        geo1.c[i]  <= in_c[i];
        geo1.ab[i] <= sto_pkg::diff_t'(in_b[i]) - sto_pkg::diff_t'(in_a[i]);
        geo1.ac[i] <= sto_pkg::diff_t'(in_c[i]) - sto_pkg::diff_t'(in_a[i]);
        geo1.bc[i] <= sto_pkg::diff_t'(in_c[i]) - sto_pkg::diff_t'(in_b[i]);
        s1_ap[i]   <= sto_pkg::diff_t'(pc[i]) - sto_pkg::diff_t'(in_a[i]);
        s1_bp[i]   <= sto_pkg::diff_t'(pc[i]) - sto_pkg::diff_t'(in_b[i]);
        s1_cp[i]   <= sto_pkg::diff_t'(pc[i]) - sto_pkg::diff_t'(in_c[i]);
      end
      geo1.last <= last_triangle;
    end
  end

  // Stage 2: the eighteen component products of d1..d6.
  sto_pkg::diff_t s1_l [6][3];
  sto_pkg::diff_t s1_r [6][3];
  sto_pkg::prod_t s2_p [6][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_l[0][i] = geo1.ab[i]; s1_r[0][i] = s1_ap[i];
      s1_l[1][i] = geo1.ac[i]; s1_r[1][i] = s1_ap[i];
      s1_l[2][i] = geo1.ab[i]; s1_r[2][i] = s1_bp[i];
      s1_l[3][i] = geo1.ac[i]; s1_r[3][i] = s1_bp[i];
      s1_l[4][i] = geo1.ab[i]; s1_r[4][i] = s1_cp[i];
      s1_l[5][i] = geo1.ac[i]; s1_r[5][i] = s1_cp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        for (int i = 0; i < 3; i++) begin
          s2_p[k][i] <= s1_l[k][i] * s1_r[k][i];
        end
      end
      geo2 <= geo1;
    end
  end

  // Stage 3: dot product sums.
  sto_pkg::dot_t s3_d [6];
  sto_pkg::dot_t s4_d [6];
  sto_pkg::dot_t s5_d [6];
  sto_pkg::dot_t s6_d [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        s3_d[k] <= sto_pkg::dot_t'(s2_p[k][0]) + sto_pkg::dot_t'(s2_p[k][1])
                   + sto_pkg::dot_t'(s2_p[k][2]);
      end
      geo3 <= geo2;
    end
  end

  // Stages 4 and 5: the six cross products of the region values.
  localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

  sto_pkg::vprod_t m [6];

  for (genvar j = 0; j < 6; j++) begin : g_mul
    sto_mul #(
      .W (sto_pkg::DOT_W)
    ) u_mul (
      .clk (clk),
      .en  (adv),
      .a   (s3_d[MA[j]]),
      .b   (s3_d[MB[j]]),
      .p   (m[j])
    );
  end

  sto_pkg::val_t s6_vc, s6_vb, s6_va;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_d  <= s3_d;
      s5_d  <= s4_d;
      s6_d  <= s5_d;
      geo4  <= geo3;
      geo5  <= geo4;
      geo6  <= geo5;
      s6_vc <= sto_pkg::val_t'(m[0]) - sto_pkg::val_t'(m[1]);
      s6_vb <= sto_pkg::val_t'(m[2]) - sto_pkg::val_t'(m[3]);
      s6_va <= sto_pkg::val_t'(m[4]) - sto_pkg::val_t'(m[5]);
    end
  end

  // Stage 7: region selection.
  sto_pkg::wnum_t        n1_next, dn1_next, n2_next, dn2_next;
  sto_pkg::coord_t [2:0] base_next;
  sto_pkg::diff_t  [2:0] e1_next, e2_next;

  always_comb begin
    sto_pkg::wnum_t tot;
    sto_pkg::wnum_t nbc;
    tot       = sto_pkg::wnum_t'(s6_va) + sto_pkg::wnum_t'(s6_vb) + sto_pkg::wnum_t'(s6_vc);
    nbc       = sto_pkg::wnum_t'(s6_d[3]) - sto_pkg::wnum_t'(s6_d[2]);
    base_next = geo6.a;
    e1_next   = '0;
    e2_next   = '0;
    n1_next   = '0;
    dn1_next  = '0;
    n2_next   = '0;
    dn2_next  = '0;
    if (s6_d[0] <= 0 && s6_d[1] <= 0) begin
      base_next = geo6.a;
    end else if (s6_d[2] >= 0 && s6_d[3] <= s6_d[2]) begin
      base_next = geo6.b;
    end else if (s6_vc <= 0 && s6_d[0] >= 0 && s6_d[2] <= 0) begin
      n1_next  = sto_pkg::wnum_t'(s6_d[0]);
      dn1_next = sto_pkg::wnum_t'(s6_d[0]) - sto_pkg::wnum_t'(s6_d[2]);
      e1_next  = geo6.ab;
    end else if (s6_d[5] >= 0 && s6_d[4] <= s6_d[5]) begin
      base_next = geo6.c;
    end else if (s6_vb <= 0 && s6_d[1] >= 0 && s6_d[5] <= 0) begin
      n1_next  = sto_pkg::wnum_t'(s6_d[1]);
      dn1_next = sto_pkg::wnum_t'(s6_d[1]) - sto_pkg::wnum_t'(s6_d[5]);
      e1_next  = geo6.ac;
    end else if (s6_va <= 0 && s6_d[3] >= s6_d[2] && s6_d[4] >= s6_d[5]) begin
      n1_next   = nbc;
      dn1_next  = nbc + sto_pkg::wnum_t'(s6_d[4]) - sto_pkg::wnum_t'(s6_d[5]);
      base_next = geo6.b;
      e1_next   = geo6.bc;
    end else begin
      n1_next  = sto_pkg::wnum_t'(s6_vb);
      dn1_next = tot;
      n2_next  = sto_pkg::wnum_t'(s6_vc);
      dn2_next = tot;
      e1_next  = geo6.ab;
      e2_next  = geo6.ac;
    end
  end

  sto_pkg::wnum_t        s7_n1, s7_dn1, s7_n2, s7_dn2;
  sto_pkg::coord_t [2:0] s7_base;
  sto_pkg::diff_t  [2:0] s7_e1, s7_e2;
  logic                  s7_last;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_n1   <= n1_next;
      s7_dn1  <= dn1_next;
      s7_n2   <= n2_next;
      s7_dn2  <= dn2_next;
      s7_base <= base_next;
      s7_e1   <= e1_next;
      s7_e2   <= e2_next;
      s7_last <= geo6.last;
    end
  end

  // Stage 8: weight special cases and divider operands.
  fin_t           fin_next;
  fin_t           side [0:N];
  logic [DVW-1:0] dnum1, dden1, dnum2, dden2;
  logic [N-1:0]   quo1, quo2;

  always_comb begin
    fin_next.base = s7_base;
    fin_next.e1   = s7_e1;
    fin_next.e2   = s7_e2;
    fin_next.z1   = (s7_dn1 <= 0) || (s7_n1 <= 0);
    fin_next.o1   = s7_n1 >= s7_dn1;
    fin_next.z2   = (s7_dn2 <= 0) || (s7_n2 <= 0);
    fin_next.o2   = s7_n2 >= s7_dn2;
    fin_next.last = s7_last;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= fin_next;
      for (int k = 1; k <= N; k++) begin
        side[k] <= side[k-1];
      end
      dnum1 <= s7_n1[DVW-1:0];
      dden1 <= s7_dn1[DVW-1:0];
      dnum2 <= s7_n2[DVW-1:0];
      dden2 <= s7_dn2[DVW-1:0];
    end
  end

  sto_div #(
    .W (DVW),
    .N (N)
  ) u_div1 (
    .clk (clk),
    .en  (adv),
    .num (dnum1),
    .den (dden1),
    .quo (quo1)
  );

  sto_div #(
    .W (DVW),
    .N (N)
  ) u_div2 (
    .clk (clk),
    .en  (adv),
    .num (dnum2),
    .den (dden2),
    .quo (quo2)
  );

  // Placement: weighted direction products.
  sto_pkg::wgt_t   q1, q2;
  sto_pkg::plc_t   p1_m1 [3];
  sto_pkg::plc_t   p1_m2 [3];
  sto_pkg::coord_t p1_base [3];
  logic            p1_last;

  always_comb begin
    fin_t f;
    f  = side[N];
    q1 = f.z1 ? '0 : (f.o1 ? (sto_pkg::wgt_t'(1) << N) : {1'b0, quo1});
    q2 = f.z2 ? '0 : (f.o2 ? (sto_pkg::wgt_t'(1) << N) : {1'b0, quo2});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_m1[i]   <= sto_pkg::diff_t'(side[N].e1[i]) * $signed({1'b0, q1});
        p1_m2[i]   <= sto_pkg::diff_t'(side[N].e2[i]) * $signed({1'b0, q2});
        p1_base[i] <= sto_pkg::coord_t'(side[N].base[i]);
      end
      p1_last <= side[N].last;
    end
  end

  // Rounding and saturation of the closest point.
  sto_pkg::coord_t nr_next [3];
  sto_pkg::coord_t p2_nr [3];
  logic            p2_last;

  always_comb begin
    sto_pkg::plc_t acc;
    logic signed [sto_pkg::PLC_W-N-1:0] y;
    for (int i = 0; i < 3; i++) begin
      acc = (sto_pkg::plc_t'(p1_base[i]) <<< N) + p1_m1[i] + p1_m2[i]
            + (sto_pkg::plc_t'(1) <<< (N - 1));
      y   = acc[sto_pkg::PLC_W-1:N];
      if (y[sto_pkg::PLC_W-N-1:sto_pkg::COORD_W-1] == '0 ||
          y[sto_pkg::PLC_W-N-1:sto_pkg::COORD_W-1] == '1) begin
        nr_next[i] = y[sto_pkg::COORD_W-1:0];
      end else begin
        nr_next[i] = {y[sto_pkg::PLC_W-N-1], {(sto_pkg::COORD_W-1){~y[sto_pkg::PLC_W-N-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_nr   <= nr_next;
      p2_last <= p1_last;
    end
  end

  // Squared distance terms.
  sto_pkg::prod_t              p3_sq [3];
  sto_pkg::coord_t             p3_nr [3];
  logic [2*sto_pkg::RAD_W-1:0] p3_rsq;
  logic                        p3_last;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p3_sq[i] <= (sto_pkg::diff_t'(pc[i]) - sto_pkg::diff_t'(p2_nr[i]))
                    * (sto_pkg::diff_t'(pc[i]) - sto_pkg::diff_t'(p2_nr[i]));
      end
      p3_nr   <= p2_nr;
      p3_rsq  <= rad * rad;
      p3_last <= p2_last;
    end
  end

  // Output register.
  logic [sto_pkg::DIST_W-1:0] dist_next;

  always_comb begin
    logic [2*sto_pkg::DIFF_W:0] sum;
    sum = (2*sto_pkg::DIFF_W+1)'($unsigned(p3_sq[0]))
          + (2*sto_pkg::DIFF_W+1)'($unsigned(p3_sq[1]))
          + (2*sto_pkg::DIFF_W+1)'($unsigned(p3_sq[2]));
    if (sum[2*sto_pkg::DIFF_W:sto_pkg::DIST_W] != '0) begin
      dist_next = '1;
    end else begin
      dist_next = sum[sto_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_squared <= dist_next;
      hit          <= dist_next < sto_pkg::DIST_W'(p3_rsq);
      near_x       <= p3_nr[0];
      near_y       <= p3_nr[1];
      near_z       <= p3_nr[2];
      last_out     <= p3_last;
    end
  end

`ifndef SYNTHESIS
  a_sat_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> dist_squared != '1)
    else $error("saturated distance reported as a hit");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid && rad == '0 |-> !hit)
    else $error("hit with zero radius");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> rtl/core/sto_mul.sv
`timescale 1ns / 1ps

module sto_mul #(
  parameter int W = sto_pkg::DOT_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H = W / 2;
  localparam int L = W - H;

  logic signed [2*H-1:0] hh;
  logic signed [H+L:0]   hl;
  logic signed [H+L:0]   lh;
  logic [2*L-1:0]        ll;

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= $signed(a[W-1:L]) * $signed(b[W-1:L]);
      hl <= $signed(a[W-1:L]) * $signed({1'b0, b[L-1:0]});
      lh <= $signed({1'b0, a[L-1:0]}) * $signed(b[W-1:L]);
      ll <= a[L-1:0] * b[L-1:0];
      p  <= ((2*W)'(hh) <<< (2*L)) + (((2*W)'(hl) + (2*W)'(lh)) <<< L)
            + (2*W)'($signed({1'b0, ll}));
    end
  end

endmodule

>>> rtl/core/sto_div.sv
`timescale 1ns / 1ps

module sto_div #(
  parameter int W = sto_pkg::NUM_W - 1,
  parameter int N = sto_pkg::FRAC_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [N-1:0] quo
);

  logic [W-1:0] rem [1:N];
  logic [W-1:0] dv  [1:N];
  logic [N-1:0] qt  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0] r_i;
    logic [W-1:0] d_i;
    logic [N-1:0] q_i;
    logic [W:0]   t;
    if (k == 0) begin : g_first
      assign r_i = num;
      assign d_i = den;
      assign q_i = '0;
    end else begin : g_next
      assign r_i = rem[k];
      assign d_i = dv[k];
      assign q_i = qt[k];
    end
    assign t = {r_i, 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= d_i;
        if (t >= {1'b0, d_i}) begin
          rem[k+1] <= W'(t - {1'b0, d_i});
          qt[k+1]  <= {q_i[N-2:0], 1'b1};
        end else begin
          rem[k+1] <= t[W-1:0];
          qt[k+1]  <= {q_i[N-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qt[N];

endmodule
